FILE: rtl/core/lcc_pkg.sv
// lcc_pkg: shared constants and types for the LRU cache cost block.
// Used by lcc_cell and lru_cache_hit_cost; depends on nothing else.
`default_nettype none

package lcc_pkg;

	localparam int LCC_CAPACITY  = 16;
	localparam int LCC_KEY_WIDTH = 32;

	localparam int CITY_KEY_W     = 32;
	localparam int CACHE_SIZE_W   = 5;
	localparam int COST_W         = 3;
	localparam int TOTAL_W        = 32;
	localparam int ENTRIES_W      = 5;

	localparam logic [CACHE_SIZE_W-1:0] CACHE_SIZE_RESET = 5'd16;
	localparam logic [COST_W-1:0]       COST_HIT         = 3'd1;
	localparam logic [COST_W-1:0]       COST_MISS        = 3'd5;

	// broadcast control for every cell of the recency chain
	typedef struct packed {
		logic commit;   // a transaction is accepted this cycle
		logic hit;      // the lookup found the key
	} lcc_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/lcc_cell.sv
// lcc_cell: one slot of the recency chain; holds one key, compares it and
// takes its neighbor's key on a shift. Depends on lcc_pkg.
`default_nettype none

module lcc_cell #(
	parameter int IDX       = 0,
	parameter int KEY_WIDTH = 32,
	parameter int CNT_W     = 5
) (
	input  wire                   clk,
	input  lcc_pkg::lcc_ctl_t     ctl,
	input  wire  [KEY_WIDTH-1:0]  look_key,
	input  wire  [CNT_W-1:0]      occ_cut,
	input  wire  [CNT_W-1:0]      eff_size,
	input  wire  [KEY_WIDTH-1:0]  prev_key,
	input  wire                   match_in,
	output logic [KEY_WIDTH-1:0]  key_out,
	output logic                  match_out
);
	import lcc_pkg::*;

	localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

	logic [KEY_WIDTH-1:0] key_q;
	logic                 occupied;
	logic                 in_window;
	logic                 load;

	assign occupied  = IDX_C < occ_cut;
	assign in_window = IDX_C < eff_size;
	assign match_out = match_in | (occupied && (key_q == look_key));

	// hit: slots up to and including the matching one move back
	// miss: every slot inside the effective size moves back
	assign load = ctl.commit && (ctl.hit ? !match_in : in_window);

	always_ff @(posedge clk) begin
		if (load) begin
			key_q <= prev_key;
		end
	end

	assign key_out = key_q;

endmodule

`default_nettype wire

FILE: rtl/core/lru_cache_hit_cost.sv
// lru_cache_hit_cost: LRU cache of city keys with per-access cost and total.
// Top level; instantiates lcc_cell, depends on lcc_pkg.
//
// Usage:
//  - Request channel: city_key with req_valid / req_stall. A transaction is
//    taken at a clock edge with req_valid high and req_stall low.
//  - Response channel: hit, access_cost, total_cost, entries_used with
//    rsp_valid / rsp_stall. One response per request, in order.
//  - Sizes above CAPACITY act as CAPACITY. The user writes cache_size via
//    cache_size_we/_wdata only while no transaction is in flight; unchecked.
//  - Timing: the response registers load at the request edge and
//    the response is valid in the following cycle.
//  - Throughput: one request per cycle unless stalled. All slots of the cell
//    chain compare in the same cycle and the recency shift happens at the
//    request edge; the match ripple through the chain sets the critical path.
//  - Stall: while a response sits unaccepted, req_stall is high, so at most
//    one result is held; taking it frees the request side in the same cycle.
//  - Reset: occupancy and total cost go to zero, cache_size to 16, no
//    response pending. Key slots are not cleared; only occupied slots are
//    ever compared.
`default_nettype none

module lru_cache_hit_cost #(
	parameter int CAPACITY  = lcc_pkg::LCC_CAPACITY,
	parameter int KEY_WIDTH = lcc_pkg::LCC_KEY_WIDTH
) (
	input  wire                               clk,
	input  wire                               arst_n,
	// configuration
	input  wire                               cache_size_we,
	input  wire  [lcc_pkg::CACHE_SIZE_W-1:0]  cache_size_wdata,
	// request
	input  wire                               req_valid,
	output logic                              req_stall,
	input  wire  [lcc_pkg::CITY_KEY_W-1:0]    city_key,
	// response
	output logic                              rsp_valid,
	input  wire                               rsp_stall,
	output logic                              hit,
	output logic [lcc_pkg::COST_W-1:0]        access_cost,
	output logic [lcc_pkg::TOTAL_W-1:0]       total_cost,
	output logic [lcc_pkg::ENTRIES_W-1:0]     entries_used
);
	import lcc_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CACHE_SIZE_W-1:0] cache_size_q;
	logic [CNT_W-1:0]        occ_q;
	logic [TOTAL_W-1:0]      total_q;
	logic                    rsp_valid_q;
	logic                    hit_q;
	logic [COST_W-1:0]       cost_q;
	logic [ENTRIES_W-1:0]    entries_q;

	logic                    accept;
	logic [63:0]             key_ext;
	logic [KEY_WIDTH-1:0]    look_key;
	logic [CNT_W-1:0]        eff_size;
	logic [CNT_W-1:0]        occ_cut;
	logic [CNT_W-1:0]        occ_next;
	logic [31:0]             occ_next_ext;
	logic                    hit_w;
	logic [COST_W-1:0]       cost_w;
	logic [TOTAL_W:0]        total_sum;
	logic [TOTAL_W-1:0]      total_next;
	lcc_ctl_t                ctl;

	logic [KEY_WIDTH-1:0]    key_chain   [CAPACITY+1];
	logic                    match_chain [CAPACITY+1];

	// handshake: single response register, refilled as it drains
	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;

	// key reduced to KEY_WIDTH bits (zero-extended when wider than the port)
	assign key_ext  = 64'(city_key);
	assign look_key = key_ext[KEY_WIDTH-1:0];

	// effective size and occupancy cut after a size change
	always_comb begin
		if (32'(cache_size_q) > 32'(CAPACITY)) begin
			eff_size = CNT_W'(CAPACITY);
		end else begin
			eff_size = CNT_W'(cache_size_q);
		end
		occ_cut = (occ_q > eff_size) ? eff_size : occ_q;
	end

	assign ctl.commit = accept;
	assign ctl.hit    = hit_w;

	assign key_chain[0]   = look_key;
	assign match_chain[0] = 1'b0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		lcc_cell #(
			.IDX       (i),
			.KEY_WIDTH (KEY_WIDTH),
			.CNT_W     (CNT_W)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.look_key  (look_key),
			.occ_cut   (occ_cut),
			.eff_size  (eff_size),
			.prev_key  (key_chain[i]),
			.match_in  (match_chain[i]),
			.key_out   (key_chain[i+1]),
			.match_out (match_chain[i+1])
		);
	end

	assign hit_w = match_chain[CAPACITY];

	// occupancy grows only on a miss with room left
	always_comb begin
		if (!hit_w && (eff_size != '0) && (occ_cut < eff_size)) begin
			occ_next = occ_cut + CNT_W'(1);
		end else begin
			occ_next = occ_cut;
		end
		occ_next_ext = 32'(occ_next);
		cost_w       = hit_w ? COST_HIT : COST_MISS;
		total_sum    = {1'b0, total_q} + (TOTAL_W+1)'(cost_w);
		total_next   = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cache_size_q <= CACHE_SIZE_RESET;
			occ_q        <= '0;
			total_q      <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cache_size_we) begin
				cache_size_q <= cache_size_wdata;
			end
			if (accept) begin
				occ_q       <= occ_next;
				total_q     <= total_next;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			hit_q     <= hit_w;
			cost_q    <= cost_w;
			entries_q <= occ_next_ext[ENTRIES_W-1:0];
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign hit          = hit_q;
	assign access_cost  = cost_q;
	assign total_cost   = total_q;
	assign entries_used = entries_q;

	// occupancy never exceeds the chain length
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(occ_q) <= 32'(CAPACITY))
		else $error("occupancy beyond capacity");

	// a hit needs at least one occupied slot
	a_hit_occupied: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && hit_w) |-> (occ_cut != '0))
		else $error("hit with empty cache");

	// response cost agrees with the hit flag
	a_cost_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> ((hit_q && cost_q == COST_HIT) || (!hit_q && cost_q == COST_MISS)))
		else $error("cost does not match hit");

	// the running total never goes down
	a_total_mono: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (total_q >= $past(total_q)))
		else $error("total cost decreased");

	// every accepted request leaves a response
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid_q)
		else $error("response missing after request");

endmodule

`default_nettype wire
